// ===== hdl/framebuffer_raster_engine_core_defines.svh =====
// assertion helpers for the raster engine, sampled on clk, off while rst_n is low
`ifndef FRAMEBUFFER_RASTER_ENGINE_CORE_DEFINES_SVH
`define FRAMEBUFFER_RASTER_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define FRE_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fre check failed: same-cycle implication");

// next-cycle implication
`define FRE_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fre check failed: next-cycle implication");

`endif

// ===== hdl/fre_pkg.sv =====
package fre_pkg;

    // default geometry
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;
    localparam int BLOCK_WIDTH_DEF   = 24;
    localparam int BLOCK_HEIGHT_DEF  = 33;

    // field widths
    localparam int OP_W      = 3;
    localparam int FIELD_W   = 9;
    localparam int COLOR_W   = 16;
    localparam int COUNT_W   = 17;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // signed coordinate width, covers -511 .. 2047
    localparam int COORD_W   = 12;
    // row counter width, covers up to 1024 rows
    localparam int ROWS_W    = 11;
    // circle half width and its square
    localparam int HALF_W    = 10;
    localparam int HSQ_W     = 19;
    localparam int RSQ_W     = 18;

    // command codes
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_PIXEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_HRUN   = 3'd2;
    localparam logic [OP_W-1:0] OP_VRUN   = 3'd3;
    localparam logic [OP_W-1:0] OP_BLOCK  = 3'd4;
    localparam logic [OP_W-1:0] OP_CIRCLE = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic circ_rem;
        logic circ_step;
        logic span_set;
        logic write;
        logic row_next;
        logic rd_capture;
        logic result;
    } fre_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            rows_zero;
        logic            rows_last;
        logic            settled;
        logic            run_last;
        logic            out_free;
    } fre_status_t;

endpackage

// ===== hdl/fre_ctrl.sv =====
module fre_ctrl
    import fre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  fre_status_t status,
    output fre_cmd_t    cmd
);

    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_ROW     = 4'd2;
    localparam logic [3:0] ST_REM     = 4'd3;
    localparam logic [3:0] ST_ADJ     = 4'd4;
    localparam logic [3:0] ST_SET     = 4'd5;
    localparam logic [3:0] ST_RUN     = 4'd6;
    localparam logic [3:0] ST_NEXT    = 4'd7;
    localparam logic [3:0] ST_RD_SET  = 4'd8;
    localparam logic [3:0] ST_RD_MEM  = 4'd9;
    localparam logic [3:0] ST_RD_DATA = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       init_reg;
    logic       init_next;

    assign s_tready = (state_reg == ST_IDLE);

    // sequencing of rows and spans
    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.load   = 1'b1;
                cmd.init   = 1'b1;
                state_next = ST_ROW;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (status.op == OP_READ && !init_reg)
                    state_next = ST_RD_SET;
                else if (status.rows_zero)
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                else if (status.op == OP_CIRCLE)
                    state_next = ST_REM;
                else
                    state_next = ST_SET;
            end
            ST_REM:
            begin
                cmd.circ_rem = 1'b1;
                state_next   = ST_ADJ;
            end
            ST_ADJ:
            begin
                if (status.settled)
                    state_next = ST_SET;
                else
                    cmd.circ_step = 1'b1;
            end
            ST_SET:
            begin
                cmd.span_set = 1'b1;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.write = 1'b1;
                if (status.run_last)
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.row_next = 1'b1;
                if (status.rows_last)
                begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                    init_next  = 1'b0;
                end
                else if (status.op == OP_CIRCLE)
                    state_next = ST_REM;
                else
                    state_next = ST_SET;
            end
            ST_RD_SET:
            begin
                cmd.span_set = 1'b1;
                state_next   = ST_RD_MEM;
            end
            ST_RD_MEM:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
        end
    end

endmodule

// ===== hdl/fre_datapath.sv =====
module fre_datapath
    import fre_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int BLOCK_WIDTH   = BLOCK_WIDTH_DEF,
    parameter int BLOCK_HEIGHT  = BLOCK_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  fre_cmd_t             cmd,
    output fre_status_t          status
);

    localparam int MEM_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic signed [COORD_W-1:0] COL_MAX = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] ROW_MAX = COORD_W'(SCREEN_HEIGHT - 1);

    // input item fields
    logic [OP_W-1:0]    in_op;
    logic [FIELD_W-1:0] in_px;
    logic [FIELD_W-1:0] in_py;
    logic [FIELD_W-1:0] in_ext;
    logic [COLOR_W-1:0] in_color;
    logic signed [COORD_W-1:0] px_s;
    logic signed [COORD_W-1:0] py_s;
    logic signed [COORD_W-1:0] ext_s;
    logic [RSQ_W-1:0]   ext_sq;

    assign in_op    = s_tuser;
    assign in_px    = s_tdata[8:0];
    assign in_py    = s_tdata[17:9];
    assign in_ext   = s_tdata[26:18];
    assign in_color = s_tdata[42:27];
    assign px_s     = $signed(COORD_W'(in_px));
    assign py_s     = $signed(COORD_W'(in_py));
    assign ext_s    = $signed(COORD_W'(in_ext));
    assign ext_sq   = in_ext * in_ext;

    // command registers
    logic [OP_W-1:0]           op_reg, op_next;
    logic [COLOR_W-1:0]        color_reg, color_next;
    logic signed [COORD_W-1:0] lo_reg, lo_next;
    logic signed [COORD_W-1:0] hi_reg, hi_next;
    logic signed [COORD_W-1:0] row_reg, row_next;
    logic signed [COORD_W-1:0] dy_reg, dy_next;
    logic [ROWS_W-1:0]         rows_reg, rows_next;
    // circle half width tracking
    logic [RSQ_W-1:0]          rr_reg, rr_next;
    logic [RSQ_W-1:0]          rem_reg, rem_next;
    logic [HALF_W-1:0]         h_reg, h_next;
    logic [HSQ_W-1:0]          hsq_reg, hsq_next;
    // span walker
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [COORD_W-1:0]        run_reg, run_next;
    logic                      empty_reg, empty_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COLOR_W-1:0]        rd_color_reg, rd_color_next;
    logic [COLOR_W-1:0]        rdata_reg;
    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]        out_color_reg, out_color_next;
    logic [COUNT_W-1:0]        out_count_reg, out_count_next;

    logic [HALF_W-1:0]         dy_abs;
    logic [2*HALF_W-1:0]       dy_sq;
    logic [HSQ_W-1:0]          h1sq;
    logic                      dec_cond;
    logic                      inc_cond;
    logic signed [COORD_W-1:0] h_s;
    logic signed [COORD_W-1:0] span_lo;
    logic signed [COORD_W-1:0] span_hi;
    logic signed [COORD_W-1:0] lo_c;
    logic signed [COORD_W-1:0] hi_c;
    logic                      span_empty;
    logic [ADDR_W-1:0]         span_addr;
    logic                      we;

    logic [COLOR_W-1:0] mem [MEM_DEPTH];

    // circle row remainder and half-width step
    assign dy_abs   = dy_reg[COORD_W-1] ? HALF_W'(-dy_reg) : HALF_W'(dy_reg);
    assign dy_sq    = dy_abs * dy_abs;
    assign h1sq     = hsq_reg + HSQ_W'({h_reg, 1'b1});
    assign dec_cond = (h_reg != '0) && (hsq_reg > HSQ_W'(rem_reg));
    assign inc_cond = (h1sq <= HSQ_W'(rem_reg));

    // clipped span of the current row
    assign h_s        = $signed(COORD_W'(h_reg));
    assign span_lo    = (op_reg == OP_CIRCLE) ? lo_reg - h_s : lo_reg;
    assign span_hi    = (op_reg == OP_CIRCLE) ? lo_reg + h_s : hi_reg;
    assign lo_c       = (span_lo < 0) ? '0 : span_lo;
    assign hi_c       = (span_hi > COL_MAX) ? COL_MAX : span_hi;
    assign span_empty = (row_reg < 0) || (row_reg > ROW_MAX) || (lo_c > hi_c);
    assign span_addr  = ADDR_W'(row_reg[COORD_W-3:0]) * ADDR_W'(SCREEN_WIDTH)
                      + ADDR_W'(lo_c[COORD_W-3:0]);

    assign we = cmd.write && !empty_reg;

    always_comb
    begin
        op_next        = op_reg;
        color_next     = color_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        row_next       = row_reg;
        dy_next        = dy_reg;
        rows_next      = rows_reg;
        rr_next        = rr_reg;
        rem_next       = rem_reg;
        h_next         = h_reg;
        hsq_next       = hsq_reg;
        addr_next      = addr_reg;
        run_next       = run_reg;
        empty_next     = empty_reg;
        count_next     = count_reg;
        rd_color_next  = rd_color_reg;
        out_color_next = out_color_reg;
        out_count_next = out_count_reg;

        // item geometry
        if (cmd.load)
        begin
            op_next       = in_op;
            color_next    = in_color;
            lo_next       = px_s;
            hi_next       = px_s;
            row_next      = py_s;
            dy_next       = '0;
            rows_next     = '0;
            rr_next       = ext_sq;
            h_next        = '0;
            hsq_next      = '0;
            count_next    = '0;
            rd_color_next = '0;
            if (cmd.init)
            begin
                op_next    = OP_CLEAR;
                color_next = '0;
                lo_next    = '0;
                hi_next    = COL_MAX;
                row_next   = '0;
                rows_next  = ROWS_W'(SCREEN_HEIGHT);
            end
            else
            begin
                case (in_op)
                    OP_PIXEL:
                    begin
                        rows_next = ROWS_W'(1);
                    end
                    OP_HRUN:
                    begin
                        hi_next   = px_s + ext_s - COORD_W'(1);
                        rows_next = (in_ext != '0) ? ROWS_W'(1) : '0;
                    end
                    OP_VRUN:
                    begin
                        rows_next = ROWS_W'(in_ext);
                    end
                    OP_BLOCK:
                    begin
                        hi_next   = px_s + COORD_W'(BLOCK_WIDTH - 1);
                        rows_next = ROWS_W'(BLOCK_HEIGHT);
                    end
                    OP_CIRCLE:
                    begin
                        row_next  = py_s - ext_s;
                        dy_next   = -ext_s;
                        rows_next = ROWS_W'({in_ext, 1'b1});
                    end
                    OP_CLEAR:
                    begin
                        lo_next   = '0;
                        hi_next   = COL_MAX;
                        row_next  = '0;
                        rows_next = ROWS_W'(SCREEN_HEIGHT);
                    end
                    default:
                    begin
                        rows_next = '0;
                    end
                endcase
            end
        end

        // remainder of the radius square for this row
        if (cmd.circ_rem)
            rem_next = rr_reg - RSQ_W'(dy_sq);

        // move half width one step toward the integer square root
        if (cmd.circ_step)
        begin
            if (dec_cond)
            begin
                h_next   = h_reg - HALF_W'(1);
                hsq_next = hsq_reg - HSQ_W'({h_reg, 1'b0}) + HSQ_W'(1);
            end
            else if (inc_cond)
            begin
                h_next   = h_reg + HALF_W'(1);
                hsq_next = h1sq;
            end
        end

        // span start address and length
        if (cmd.span_set)
        begin
            addr_next  = span_addr;
            run_next   = COORD_W'(hi_c - lo_c);
            empty_next = span_empty;
        end

        // one pixel a cycle
        if (we)
        begin
            addr_next  = addr_reg + ADDR_W'(1);
            run_next   = run_reg - COORD_W'(1);
            count_next = count_reg + COUNT_W'(1);
        end

        if (cmd.row_next)
        begin
            row_next  = row_reg + COORD_W'(1);
            dy_next   = dy_reg + COORD_W'(1);
            rows_next = rows_reg - ROWS_W'(1);
        end

        if (cmd.rd_capture)
            rd_color_next = empty_reg ? '0 : rdata_reg;

        if (cmd.result)
        begin
            out_color_next = rd_color_reg;
            out_count_next = count_reg;
        end
    end

    // result holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        color_reg     <= color_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        row_reg       <= row_next;
        dy_reg        <= dy_next;
        rows_reg      <= rows_next;
        rr_reg        <= rr_next;
        rem_reg       <= rem_next;
        h_reg         <= h_next;
        hsq_reg       <= hsq_next;
        addr_reg      <= addr_next;
        run_reg       <= run_next;
        empty_reg     <= empty_next;
        count_reg     <= count_next;
        rd_color_reg  <= rd_color_next;
        out_color_reg <= out_color_next;
        out_count_reg <= out_count_next;
    end

    // frame store, one port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr_reg] <= color_reg;
        rdata_reg <= mem[addr_reg];
    end

    assign status.op        = op_reg;
    assign status.rows_zero = (rows_reg == '0);
    assign status.rows_last = (rows_reg == ROWS_W'(1));
    assign status.settled   = !dec_cond && !inc_cond;
    assign status.run_last  = empty_reg || (run_reg == '0);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_color_reg});

endmodule

// ===== hdl/framebuffer_raster_engine_core.sv =====
// Raster fill engine over a 16-bit frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels.
// Input channel s_*: one drawing command per item (read, pixel, horizontal run,
// vertical run, block, filled circle, clear). Output channel m_*: one result per
// command with the color read and the count of on-screen pixels written.
// The engine handles one command at a time; s_tready is high only while it waits.
// Every command but a read walks row spans, writing one pixel per cycle through the
// single store port. Each row has a setup step, its run over the clipped width and an
// advance step; a circle adds per row a remainder step, half-width steps and a settle
// step. A read passes address setup, the store access and the data capture before the
// result register. After reset the engine sweeps the store to zero, one pixel per
// cycle; no item is taken before the sweep ends.
// The result sits in an output register; when the receiver stalls, the next
// command may still be taken and run, and it waits only to hand its result over.
`include "framebuffer_raster_engine_core_defines.svh"

module framebuffer_raster_engine_core
    import fre_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int BLOCK_WIDTH   = BLOCK_WIDTH_DEF,
    parameter int BLOCK_HEIGHT  = BLOCK_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x[8:0], pos_y[17:9], extent[26:18], pixel_color[42:27], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[2:0]
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_color[15:0], pixels_written[32:16], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    fre_cmd_t    cmd;
    fre_status_t status;

    fre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fre_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BLOCK_WIDTH   (BLOCK_WIDTH),
        .BLOCK_HEIGHT  (BLOCK_HEIGHT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    // the store is never written while waiting for an item
    `FRE_ASSERT_IMPL(a_no_write_idle, s_tready, !cmd.write)
    // an accepted item makes the engine busy
    `FRE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a new result only appears after the controller hands one over
    `FRE_ASSERT_IMPL(a_result_source, $rose(m_tvalid), $past(cmd.result))

endmodule
